### rtl/fbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbb_pkg
// Shared widths, limits and register map of the foreground bounding box.
// ----------------------------------------------------------------------------
package fbb_pkg;

   // frame geometry
   localparam int MAX_DIM        = 4096;
   localparam int DIM_W          = 13;   // width / height register
   localparam int COORD_W        = 12;   // column / row coordinate

   // background colours
   localparam int NUM_BG_COLORS  = 4;
   localparam int BG_REGS        = 4;    // colour registers in the map
   localparam int COLOR_W        = 24;
   localparam int CHAN_W         = 8;
   localparam int COUNT_W        = 3;

   // register port
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int REG_IDX_W      = 3;

   // register map, index = byte address / 4
   typedef enum logic [REG_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_BG_COUNT     = 3'd2,
      REG_BG_COLOR_0   = 3'd3,
      REG_BG_COLOR_1   = 3'd4,
      REG_BG_COLOR_2   = 3'd5,
      REG_BG_COLOR_3   = 3'd6
   } reg_idx_type;

   // reset values
   localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd480;
   localparam logic [COUNT_W-1:0] BG_COUNT_RST     = 3'd1;

   // clamp a frame dimension to 1 .. MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/foreground_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foreground_bounding_box
// Bounding box of the foreground pixels of a raster-order RGB frame.
// ----------------------------------------------------------------------------
// One pixel request can be taken every clock, save for the stall below. An
// accepted pixel sits in an input register, where it is compared against the
// background colours, and is folded into the column/row trackers as it leaves
// that register. The box of a frame is registered onto the rsp_ port as the
// frame's last pixel leaves the input register. The only stall is a last
// pixel of a frame meeting a result that has not yet been taken; every other
// pixel passes even while a result waits. Column and row are counted from
// frame_width and frame_height (0 acts as 1, above 4096 acts as 4096); a
// frame with no foreground gives found = 0 and an all-zero box. Registers
// sit at byte addresses 4*i: width, height, background count, then the four
// background colours (channel 0 in bits 7:0). Write them only while no pixel
// is in flight; the position counters carry over a change of frame size.
// ----------------------------------------------------------------------------
module foreground_bounding_box
   import fbb_pkg::*;
#(
   parameter int NUM_BG = NUM_BG_COLORS
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel requests
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAN_W-1:0]     req_pixel_ch0,
   input  logic [CHAN_W-1:0]     req_pixel_ch1,
   input  logic [CHAN_W-1:0]     req_pixel_ch2,
   // box results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [COORD_W-1:0]    rsp_left,
   output logic [COORD_W-1:0]    rsp_top,
   output logic [COORD_W-1:0]    rsp_right,
   output logic [COORD_W-1:0]    rsp_bottom,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int BG_CNT_W = $clog2(NUM_BG + 1) + 1;

   // configuration
   logic [DIM_W-1:0]   frame_width_ff;
   logic [DIM_W-1:0]   frame_height_ff;
   logic [COUNT_W-1:0] bg_count_ff;
   logic [COLOR_W-1:0] bg_color_ff [NUM_BG];
   logic               cfg_wr;
   reg_idx_type        cfg_idx;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic [COLOR_W-1:0] s1_color_ff;
   logic               req_take;

   // trackers
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] min_col_ff, min_col_in;
   logic [COORD_W-1:0] min_row_ff, min_row_in;
   logic [COORD_W-1:0] max_col_ff, max_col_in;
   logic [COORD_W-1:0] max_row_ff, max_row_in;
   logic               any_fg_ff, any_fg_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [COORD_W-1:0] rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;

   // datapath
   logic [DIM_W-1:0]    width_eff, height_eff;
   logic [BG_CNT_W-1:0] count_eff;
   logic                is_bg, fg;
   logic                col_last, row_last, frame_end;
   logic                s1_adv, fire, emit;
   logic [COORD_W-1:0]  min_col_nx, min_row_nx, max_col_nx, max_row_nx;
   logic                any_fg_nx;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         bg_count_ff     <= BG_COUNT_RST;
         for (int k = 0; k < NUM_BG; k++) begin
            bg_color_ff[k] <= '0;
         end
      end else if (cfg_wr) begin
         if (cfg_idx == REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_pwdata[DIM_W-1:0];
         end
         if (cfg_idx == REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr_pwdata[DIM_W-1:0];
         end
         if (cfg_idx == REG_BG_COUNT) begin
            bg_count_ff <= csr_pwdata[COUNT_W-1:0];
         end
         // colours past the register map stay at zero
         for (int k = 0; k < NUM_BG; k++) begin
            if (k < BG_REGS && cfg_idx == reg_idx_type'(REG_BG_COLOR_0 + k)) begin
               bg_color_ff[k] <= csr_pwdata[COLOR_W-1:0];
            end
         end
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      case (cfg_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         REG_BG_COUNT:     csr_prdata = CSR_DATA_W'(bg_count_ff);
         default: begin
            for (int k = 0; k < NUM_BG; k++) begin
               if (k < BG_REGS && cfg_idx == reg_idx_type'(REG_BG_COLOR_0 + k)) begin
                  csr_prdata = CSR_DATA_W'(bg_color_ff[k]);
               end
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- input stage
   // a pixel may wait here only if it closes a frame and the result is held
   assign s1_adv    = ~(frame_end & rsp_valid_ff & ~rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign req_take  = req_valid & req_ready;
   assign fire      = s1_valid_ff & s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_color_ff <= {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
      end
   end

   // ---------------------------------------------------------------- classify
   assign width_eff  = clamp_dim(frame_width_ff);
   assign height_eff = clamp_dim(frame_height_ff);
   assign count_eff  = ({1'b0, bg_count_ff} > (COUNT_W+1)'(NUM_BG))
                       ? BG_CNT_W'(NUM_BG) : BG_CNT_W'(bg_count_ff);

   always_comb begin
      is_bg = 1'b0;
      for (int k = 0; k < NUM_BG; k++) begin
         if (BG_CNT_W'(k) < count_eff && bg_color_ff[k] == s1_color_ff) begin
            is_bg = 1'b1;
         end
      end
   end

   assign fg        = ~is_bg;
   assign col_last  = ({1'b0, col_ff} + DIM_W'(1)) >= width_eff;
   assign row_last  = ({1'b0, row_ff} + DIM_W'(1)) >= height_eff;
   assign frame_end = col_last & row_last;
   assign emit      = fire & frame_end;

   // ---------------------------------------------------------------- trackers
   always_comb begin
      min_col_nx = (fg && col_ff < min_col_ff) ? col_ff : min_col_ff;
      min_row_nx = (fg && row_ff < min_row_ff) ? row_ff : min_row_ff;
      max_col_nx = (fg && col_ff > max_col_ff) ? col_ff : max_col_ff;
      max_row_nx = (fg && row_ff > max_row_ff) ? row_ff : max_row_ff;
      any_fg_nx  = any_fg_ff | fg;

      col_in     = col_ff;
      row_in     = row_ff;
      min_col_in = min_col_ff;
      min_row_in = min_row_ff;
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      any_fg_in  = any_fg_ff;

      if (fire) begin
         if (frame_end) begin
            // clear for the next frame
            col_in     = '0;
            row_in     = '0;
            min_col_in = '1;
            min_row_in = '1;
            max_col_in = '0;
            max_row_in = '0;
            any_fg_in  = 1'b0;
         end else begin
            col_in     = col_last ? '0 : col_ff + COORD_W'(1);
            row_in     = col_last ? row_ff + COORD_W'(1) : row_ff;
            min_col_in = min_col_nx;
            min_row_in = min_row_nx;
            max_col_in = max_col_nx;
            max_row_in = max_row_nx;
            any_fg_in  = any_fg_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         min_col_ff <= '1;
         min_row_ff <= '1;
         max_col_ff <= '0;
         max_row_ff <= '0;
         any_fg_ff  <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         min_col_ff <= min_col_in;
         min_row_ff <= min_row_in;
         max_col_ff <= max_col_in;
         max_row_ff <= max_row_in;
         any_fg_ff  <= any_fg_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      // empty frame reports an all-zero box
      if (emit) begin
         rsp_found_ff  <= any_fg_nx;
         rsp_left_ff   <= any_fg_nx ? min_col_nx : '0;
         rsp_top_ff    <= any_fg_nx ? min_row_nx : '0;
         rsp_right_ff  <= any_fg_nx ? max_col_nx : '0;
         rsp_bottom_ff <= any_fg_nx ? max_row_nx : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_left   = rsp_left_ff;
   assign rsp_top    = rsp_top_ff;
   assign rsp_right  = rsp_right_ff;
   assign rsp_bottom = rsp_bottom_ff;

   // ---------------------------------------------------------------- checks
   // a result clears the trackers for the next frame
   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      emit |=> (col_ff == '0 && row_ff == '0 && !any_fg_ff))
      else $error("trackers not cleared after frame end");

   // an empty frame carries an all-zero box
   a_empty_box_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
      (rsp_left_ff == '0 && rsp_top_ff == '0 && rsp_right_ff == '0 && rsp_bottom_ff == '0))
      else $error("empty frame with non-zero box");

   // a found box is well ordered
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |->
      (rsp_left_ff <= rsp_right_ff && rsp_top_ff <= rsp_bottom_ff))
      else $error("box corners out of order");

   // a stalled pixel blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_ready)
      else $error("request taken over a stalled pixel");

   // an accepted request reaches the input register
   a_take_holds: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted pixel lost");

endmodule

### sim/foreground_bounding_box_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foreground_bounding_box_tb
// Self-checking bench for the foreground bounding box. Whole frames of pixel
// requests are streamed in under a range of frame sizes and background
// colour sets written over the register port between frames. A bit-accurate
// box predictor in a small scoreboard class works out each frame's box, and
// every box on the rsp_ port is checked field by field in order. Both
// handshakes idle at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module foreground_bounding_box_tb;
   import fbb_pkg::*;

   // one frame's box, as seen on the rsp_ port
   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } bbox_type;

   // register index past the end of the map, writes there are dropped
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   localparam int IDLE_PCT       = 8;
   localparam int DRAIN_CYCLES   = 4;
   localparam int STALL_LIMIT    = 2000;
   localparam int RANDOM_PIXELS  = 750;

   // directed colours
   localparam logic [COLOR_W-1:0] BLACK = 24'h000000;
   localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] TEAL  = 24'h5A3C96;
   localparam logic [COLOR_W-1:0] RUST  = 24'hA5C369;

   // -------------------------------------------------------------------------
   // box predictor and store of boxes still due
   // -------------------------------------------------------------------------
   class box_scoreboard;
      logic [DIM_W-1:0]   width_reg;
      logic [DIM_W-1:0]   height_reg;
      logic [COUNT_W-1:0] count_reg;
      logic [COLOR_W-1:0] bg_colour [NUM_BG_COLORS];
      int unsigned        column, row;
      int unsigned        min_col, min_row, max_col, max_row;
      logic               any_fg;
      bbox_type           boxes_due [$];
      int                 errors;

      function new();
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         count_reg  = BG_COUNT_RST;
         foreach (bg_colour[k]) bg_colour[k] = '0;
         errors = 0;
         clear_box();
      endfunction

      function void clear_box();
         column  = 0;
         row     = 0;
         min_col = 'hFFF;
         min_row = 'hFFF;
         max_col = 0;
         max_row = 0;
         any_fg  = 1'b0;
      endfunction

      // zero acts as one, anything past the limit as the limit
      function int unsigned dim_of(input logic [DIM_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return 32'(v);
      endfunction

      function int unsigned frame_size();
         return dim_of(width_reg) * dim_of(height_reg);
      endfunction

      function int active_colours();
         return (count_reg > NUM_BG_COLORS) ? NUM_BG_COLORS : int'(count_reg);
      endfunction

      function int pending();
         return boxes_due.size();
      endfunction

      function void set_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_FRAME_WIDTH:  width_reg  = value[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_reg = value[DIM_W-1:0];
            REG_BG_COUNT:     count_reg  = value[COUNT_W-1:0];
            REG_BG_COLOR_0, REG_BG_COLOR_1, REG_BG_COLOR_2, REG_BG_COLOR_3:
               bg_colour[idx - REG_BG_COLOR_0] = value[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      // fold one accepted pixel in; the last pixel of a frame yields its box
      function void note_pixel(input logic [CHAN_W-1:0] ch0, ch1, ch2);
         logic [COLOR_W-1:0] colour;
         logic               is_bg;
         bbox_type           box;
         colour = {ch2, ch1, ch0};
         is_bg  = 1'b0;
         for (int k = 0; k < active_colours(); k++)
            if (bg_colour[k] == colour) is_bg = 1'b1;
         if (!is_bg) begin
            if (column < min_col) min_col = column;
            if (row < min_row) min_row = row;
            if (column > max_col) max_col = column;
            if (row > max_row) max_row = row;
            any_fg = 1'b1;
         end
         if (column + 1 < dim_of(width_reg)) begin
            column++;
            return;
         end
         column = 0;
         if (row + 1 < dim_of(height_reg)) begin
            row++;
            return;
         end
         // frame complete; an empty frame reports an all-zero box
         box = '0;
         if (any_fg) begin
            box.found  = 1'b1;
            box.left   = min_col[COORD_W-1:0];
            box.top    = min_row[COORD_W-1:0];
            box.right  = max_col[COORD_W-1:0];
            box.bottom = max_row[COORD_W-1:0];
         end
         boxes_due.push_back(box);
         clear_box();
      endfunction

      function void compare_field(input string name, input int unsigned want, got);
         if (want != got) begin
            errors++;
            $display("%0t: box %s mismatch, expected %0d, actual %0d", $time, name,
                     want, got);
         end
      endfunction

      function void check_box(input bbox_type got);
         bbox_type want;
         if (boxes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected box, expected none, actual found=%0d (%0d,%0d)-(%0d,%0d)",
                     $time, got.found, got.left, got.top, got.right, got.bottom);
            return;
         end
         want = boxes_due.pop_front();
         compare_field("found",  32'(want.found),  32'(got.found));
         compare_field("left",   32'(want.left),   32'(got.left));
         compare_field("top",    32'(want.top),    32'(got.top));
         compare_field("right",  32'(want.right),  32'(got.right));
         compare_field("bottom", 32'(want.bottom), 32'(got.bottom));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHAN_W-1:0]     req_pixel_ch0 = '0;
   logic [CHAN_W-1:0]     req_pixel_ch1 = '0;
   logic [CHAN_W-1:0]     req_pixel_ch2 = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [COORD_W-1:0]    rsp_left, rsp_top, rsp_right, rsp_bottom;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   box_scoreboard sb = new();
   bit            steady = 1'b0;   // no idling on either side while set
   int            pixels_sent = 0;
   int            stall_cycles = 0;

   foreground_bounding_box DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // result side: random back-pressure and box checking
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_box(bbox_type'{rsp_found, rsp_left, rsp_top, rsp_right, rsp_bottom});
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("foreground_bounding_box_tb: FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [COLOR_W-1:0] colour);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_ch0 <= colour[7:0];
      req_pixel_ch1 <= colour[15:8];
      req_pixel_ch2 <= colour[23:16];
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(colour[7:0], colour[15:8], colour[23:16]);
      pixels_sent++;
   endtask

   // drop valid, let every box due arrive, then allow the pipeline to empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // a frame of one colour with up to two pixels (by raster index) in another
   task automatic send_marked_frame(input logic [COLOR_W-1:0] plain, marked,
                                    input int mark_a, mark_b);
      int total;
      total = sb.frame_size();
      for (int i = 0; i < total; i++)
         send_pixel((i == mark_a || i == mark_b) ? marked : plain);
   endtask

   // background from the colours in use, or foreground at fg_pct percent
   function automatic logic [COLOR_W-1:0] pick_pixel(input int fg_pct);
      logic [COLOR_W-1:0] c;
      int                 n;
      n = sb.active_colours();
      if (n == 0 || $urandom_range(99) < fg_pct) begin
         if ($urandom_range(1) == 0) begin
            c = COLOR_W'($urandom);
         end else begin
            // one bit away from a background colour
            c = sb.bg_colour[$urandom_range(NUM_BG_COLORS - 1)];
            c[$urandom_range(COLOR_W - 1)] ^= 1'b1;
         end
      end else begin
         c = sb.bg_colour[$urandom_range(n - 1)];
      end
      return c;
   endfunction

   // occasionally fill the unused upper bits of a register write with junk
   function automatic logic [CSR_DATA_W-1:0] with_junk(input int unsigned field,
                                                       input int bits);
      logic [CSR_DATA_W-1:0] v;
      v = field;
      if ($urandom_range(3) == 0)
         v = v | ($urandom & ~((32'd1 << bits) - 1));
      return v;
   endfunction

   // new settings, then a few whole frames under them
   task automatic random_phase();
      int fg_pct;
      int w, h, n;
      wait_idle();
      w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      n = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      write_reg(REG_FRAME_WIDTH, with_junk(w, DIM_W));
      write_reg(REG_FRAME_HEIGHT, with_junk(h, DIM_W));
      write_reg(REG_BG_COUNT, with_junk(n, COUNT_W));
      for (int k = 0; k < NUM_BG_COLORS; k++)
         if ($urandom_range(1) == 0)
            write_reg(REG_IDX_W'(REG_BG_COLOR_0 + k),
                      with_junk($urandom_range(24'hFFFFFF), COLOR_W));
      if ($urandom_range(7) == 0)
         write_reg(REG_UNMAPPED, $urandom);
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(4))
            0:       fg_pct = 0;
            1:       fg_pct = 5;
            2:       fg_pct = 25;
            3:       fg_pct = 100;
            default: fg_pct = 50;
         endcase
         for (int i = 0; i < sb.frame_size(); i++)
            send_pixel(pick_pixel(fg_pct));
      end
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // height and colours left at reset: 1 x 480 frame, two marked rows
      write_reg(REG_FRAME_WIDTH, 32'd1);
      send_marked_frame(BLACK, 24'h000100, 2, 477);

      // no background colours at all: every pixel is foreground
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 32'd3);
      write_reg(REG_FRAME_HEIGHT, 32'd2);
      write_reg(REG_BG_COUNT, 32'd0);
      send_pixel(BLACK);
      send_pixel(WHITE);
      send_pixel(24'h0000FF);
      send_pixel(24'hFF0000);
      send_pixel(24'h00FF00);
      send_pixel(TEAL);

      // four colours in use: an empty frame, then one near miss in the middle
      wait_idle();
      write_reg(REG_BG_COLOR_0, BLACK);
      write_reg(REG_BG_COLOR_1, WHITE);
      write_reg(REG_BG_COLOR_2, TEAL);
      write_reg(REG_BG_COLOR_3, RUST);
      write_reg(REG_BG_COUNT, 32'd4);
      send_pixel(BLACK);
      send_pixel(WHITE);
      send_pixel(TEAL);
      send_pixel(RUST);
      send_pixel(BLACK);
      send_pixel(WHITE);
      send_pixel(BLACK);
      send_pixel(WHITE);
      send_pixel(TEAL);
      send_pixel(RUST);
      send_pixel(24'h7FFFFF);
      send_pixel(BLACK);

      // count past the list saturates; foreground in opposite corners
      wait_idle();
      write_reg(REG_BG_COUNT, 32'd7);
      send_pixel(24'h000001);
      send_pixel(RUST);
      send_pixel(TEAL);
      send_pixel(WHITE);
      send_pixel(BLACK);
      send_pixel(24'hFFFFFE);

      // only two colours in use: the third counts as foreground
      wait_idle();
      write_reg(REG_BG_COUNT, 32'd2);
      send_marked_frame(WHITE, TEAL, 4, -1);

      // zero frame size acts as 1 x 1; junk above the field is dropped
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 32'hFFFF_E000);
      write_reg(REG_FRAME_HEIGHT, 32'h0000_0000);
      write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
      send_pixel(BLACK);
      send_pixel(RUST);

      // all-ones width clamps to the limit, so the row runs on; a narrower
      // width written part way along ends the row and the frame at once
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 32'h0000_1FFF);
      write_reg(REG_FRAME_HEIGHT, 32'd1);
      for (int i = 0; i < 40; i++)
         send_pixel((i == 5 || i == 30) ? RUST : BLACK);
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 32'd3);
      send_pixel(BLACK);

      // random settings and frames, with a stretch at full rate on both sides
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         steady = (pixels_sent - start >= 250) && (pixels_sent - start < 500);
         random_phase();
      end
      steady = 1'b0;

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("foreground_bounding_box_tb: PASS");
      else
         $display("foreground_bounding_box_tb: FAIL");
      $finish;
   end

endmodule

### foreground_bounding_box.f
rtl/fbb_pkg.sv
rtl/foreground_bounding_box.sv
sim/foreground_bounding_box_tb.sv
